// ===== sv/esprank_pkg.sv =====
// shared types, constants and tables of the edge subset / permutation ranker
package esprank_pkg;

  localparam int GROUP_SIZE = 6;
  localparam int SLOT_COUNT = 12;
  localparam int ID_W       = 4;
  localparam int LABEL_W    = 3;
  localparam int POS_W      = 4;
  localparam int COUNT_W    = 4;
  localparam int RANK_W     = 10;
  localparam int BINOM_W    = 9;
  localparam int FACT_W     = 7;
  localparam int PERM_W     = SLOT_COUNT * ID_W;
  localparam int GROUP_W    = GROUP_SIZE * ID_W;

  localparam logic [GROUP_W-1:0] GROUP_RESET = 24'h543210;

  // stage 1 -> stage 2: per-slot first hits
  typedef struct packed {
    logic [SLOT_COUNT-1:0]              take;
    logic [SLOT_COUNT-1:0][LABEL_W-1:0] label;
    logic [SLOT_COUNT-1:0]              orient;
    logic                               bad;
  } match_t;

  // stage 2 -> stage 3: six slots in ascending order
  typedef struct packed {
    logic [GROUP_SIZE-1:0][POS_W-1:0]   pos;
    logic [GROUP_SIZE-1:0][LABEL_W-1:0] label;
    logic [GROUP_SIZE-1:0]              obits;
    logic                               bad;
  } compact_t;

  // stage 3 -> stage 4: set rank and lehmer digits
  typedef struct packed {
    logic [RANK_W-1:0]                  set_rank;
    logic [GROUP_SIZE-1:0][LABEL_W-1:0] digit;
    logic [GROUP_SIZE-1:0]              obits;
    logic                               bad;
  } rank_t;

  // final result
  typedef struct packed {
    logic [RANK_W-1:0]     slot_set_rank;
    logic [RANK_W-1:0]     order_rank;
    logic [GROUP_SIZE-1:0] orient_bits;
    logic                  invalid;
  } result_t;

  // binomial C(n, r) for n = 0..11, r = 0..7; zero elsewhere
  function automatic logic [BINOM_W-1:0] binom(input logic [POS_W-1:0] n,
                                               input logic [LABEL_W-1:0] r);
    logic [BINOM_W-1:0] row [8];
    begin
      case (n)
        4'd0:    row = '{9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        4'd1:    row = '{9'd1, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        4'd2:    row = '{9'd1, 9'd2, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        4'd3:    row = '{9'd1, 9'd3, 9'd3, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0};
        4'd4:    row = '{9'd1, 9'd4, 9'd6, 9'd4, 9'd1, 9'd0, 9'd0, 9'd0};
        4'd5:    row = '{9'd1, 9'd5, 9'd10, 9'd10, 9'd5, 9'd1, 9'd0, 9'd0};
        4'd6:    row = '{9'd1, 9'd6, 9'd15, 9'd20, 9'd15, 9'd6, 9'd1, 9'd0};
        4'd7:    row = '{9'd1, 9'd7, 9'd21, 9'd35, 9'd35, 9'd21, 9'd7, 9'd1};
        4'd8:    row = '{9'd1, 9'd8, 9'd28, 9'd56, 9'd70, 9'd56, 9'd28, 9'd8};
        4'd9:    row = '{9'd1, 9'd9, 9'd36, 9'd84, 9'd126, 9'd126, 9'd84, 9'd36};
        4'd10:   row = '{9'd1, 9'd10, 9'd45, 9'd120, 9'd210, 9'd252, 9'd210, 9'd120};
        4'd11:   row = '{9'd1, 9'd11, 9'd55, 9'd165, 9'd330, 9'd462, 9'd462, 9'd330};
        default: row = '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0};
      endcase
      binom = row[r];
    end
  endfunction

  // factorial weight of lehmer digit i: (GROUP_SIZE-1-i)!
  function automatic logic [FACT_W-1:0] fact_weight(input logic [LABEL_W-1:0] i);
    logic [FACT_W-1:0] w;
    begin
      case (i)
        3'd0:    w = 7'd120;
        3'd1:    w = 7'd24;
        3'd2:    w = 7'd6;
        3'd3:    w = 7'd2;
        3'd4:    w = 7'd1;
        3'd5:    w = 7'd1;
        default: w = 7'd0;
      endcase
      fact_weight = w;
    end
  endfunction

endpackage

// ===== sv/esprank_if.sv =====
// valid/ready channel interfaces for permutation items and rank results
interface esprank_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] edge_perm;
  logic [11:0] edge_orient;

  modport source (output valid, output edge_perm, output edge_orient, input ready);
  modport sink   (input valid, input edge_perm, input edge_orient, output ready);
endinterface

interface esprank_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] slot_set_rank;
  logic [9:0] order_rank;
  logic [5:0] orient_bits;
  logic       invalid;

  modport source (output valid, output slot_set_rank, output order_rank,
                  output orient_bits, output invalid, input ready);
  modport sink   (input valid, input slot_set_rank, input order_rank,
                  input orient_bits, input invalid, output ready);
endinterface

// ===== sv/esprank_match.sv =====
// stage 1: find the first slot holding each group piece
module esprank_match (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [esprank_pkg::GROUP_W-1:0]  group_pieces,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [esprank_pkg::PERM_W-1:0]   edge_perm,
  input  logic [esprank_pkg::SLOT_COUNT-1:0] edge_orient,
  output logic                             out_valid,
  input  logic                             out_ready,
  output esprank_pkg::match_t              out_data
);
  import esprank_pkg::*;

  match_t                data_next;
  logic [GROUP_SIZE-1:0] seen;
  logic [GROUP_SIZE-1:0] hit;
  logic                  dup;

  // repeated ids in the group make the set unrankable
  always_comb begin
    dup = 1'b0;
    for (int a = 0; a < GROUP_SIZE; a++) begin
      for (int b = a + 1; b < GROUP_SIZE; b++) begin
        if (group_pieces[ID_W*a +: ID_W] == group_pieces[ID_W*b +: ID_W]) dup = 1'b1;
      end
    end
  end

  // scan slots in ascending order, first occurrence wins
  always_comb begin
    data_next = '0;
    seen      = '0;
    hit       = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      hit = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (edge_perm[ID_W*k +: ID_W] == group_pieces[ID_W*i +: ID_W] && !seen[i]) begin
          hit[i] = 1'b1;
        end
      end
      seen = seen | hit;
      data_next.take[k] = |hit;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if (hit[i]) data_next.label[k] = LABEL_W'(i);
      end
    end
    data_next.orient = edge_orient;
    data_next.bad    = dup || !(&seen);
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/esprank_compact.sv =====
// stage 2: pack the six taken slots in ascending order
module esprank_compact (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  esprank_pkg::match_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output esprank_pkg::compact_t out_data
);
  import esprank_pkg::*;

  compact_t           data_next;
  logic [COUNT_W-1:0] cnt;

  // running count of taken slots selects the output place
  always_comb begin
    data_next = '0;
    cnt       = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (in_data.take[k]) begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
          if (cnt == COUNT_W'(i)) begin
            data_next.pos[i]                  = POS_W'(k);
            data_next.label[i]                = in_data.label[k];
            data_next.obits[GROUP_SIZE-1-i]   = in_data.orient[k];
          end
        end
      end
      cnt = cnt + COUNT_W'(in_data.take[k]);
    end
    data_next.bad = in_data.bad;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/esprank_rank.sv =====
// stage 3: combinadic sum and lehmer digits
module esprank_rank (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  esprank_pkg::compact_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output esprank_pkg::rank_t    out_data
);
  import esprank_pkg::*;

  rank_t data_next;

  // sum of C(pos_i, i+1) and count of smaller labels to the right
  always_comb begin
    data_next = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      data_next.set_rank = data_next.set_rank +
                           RANK_W'(binom(in_data.pos[i], LABEL_W'(i + 1)));
      for (int j = i + 1; j < GROUP_SIZE; j++) begin
        if (in_data.label[j] < in_data.label[i]) begin
          data_next.digit[i] = data_next.digit[i] + LABEL_W'(1);
        end
      end
    end
    data_next.obits = in_data.obits;
    data_next.bad   = in_data.bad;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/esprank_sum.sv =====
// stage 4: weight the lehmer digits and form the result
module esprank_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  esprank_pkg::rank_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output esprank_pkg::result_t out_data
);
  import esprank_pkg::*;

  result_t           data_next;
  logic [RANK_W-1:0] ord;

  // digit times factorial weight, zero fields when unrankable
  always_comb begin
    ord = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      ord = ord + RANK_W'(in_data.digit[i]) * RANK_W'(fact_weight(LABEL_W'(i)));
    end
    data_next.invalid       = in_data.bad;
    data_next.slot_set_rank = in_data.bad ? '0 : in_data.set_rank;
    data_next.order_rank    = in_data.bad ? '0 : ord;
    data_next.orient_bits   = in_data.bad ? '0 : in_data.obits;
  end

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== sv/edge_subset_permutation_rank_unit.sv =====
// Edge subset / permutation ranker: takes one transaction per clock and returns one result
// per transaction through four register stages (first-slot match, slot compaction, combinadic
// and lehmer digit, digit weighting). Any stall on the result side back-pressures the stages
// only as far as needed, so throughput stays one transaction per cycle while results are
// taken. group_pieces resets to ids 0..5 and is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while no transaction is in flight, which the block does not
// enforce. A missing group piece or a repeated group id sets invalid with all other fields zero.
module edge_subset_permutation_rank_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [esprank_pkg::GROUP_W-1:0] cfg_wr_data,
  esprank_in_if.sink                      item_in,
  esprank_out_if.source                   result_out
);
  import esprank_pkg::*;

  logic [GROUP_W-1:0] group_pieces;
  logic               m_valid, m_ready;
  logic               c_valid, c_ready;
  logic               r_valid, r_ready;
  match_t             m_data;
  compact_t           c_data;
  rank_t              r_data;
  result_t            s_data;

  // group register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_pieces <= GROUP_RESET;
    end else if (cfg_wr_en) begin
      group_pieces <= cfg_wr_data;
    end
  end

  // pipeline stages
  esprank_match u_match (
    .clk, .rst, .group_pieces,
    .in_valid (item_in.valid), .in_ready (item_in.ready),
    .edge_perm (item_in.edge_perm), .edge_orient (item_in.edge_orient),
    .out_valid (m_valid), .out_ready (m_ready), .out_data (m_data)
  );

  esprank_compact u_compact (
    .clk, .rst,
    .in_valid (m_valid), .in_ready (m_ready), .in_data (m_data),
    .out_valid (c_valid), .out_ready (c_ready), .out_data (c_data)
  );

  esprank_rank u_rank (
    .clk, .rst,
    .in_valid (c_valid), .in_ready (c_ready), .in_data (c_data),
    .out_valid (r_valid), .out_ready (r_ready), .out_data (r_data)
  );

  esprank_sum u_sum (
    .clk, .rst,
    .in_valid (r_valid), .in_ready (r_ready), .in_data (r_data),
    .out_valid (result_out.valid), .out_ready (result_out.ready), .out_data (s_data)
  );

  // result channel fields
  assign result_out.slot_set_rank = s_data.slot_set_rank;
  assign result_out.order_rank    = s_data.order_rank;
  assign result_out.orient_bits   = s_data.orient_bits;
  assign result_out.invalid       = s_data.invalid;

`ifndef NO_ASSERTIONS
  // an unrankable transaction carries all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.invalid |->
      result_out.slot_set_rank == '0 && result_out.order_rank == '0 &&
      result_out.orient_bits == '0)
    else $error("invalid result with nonzero fields");

  // ranks stay inside C(12,6) and 6!
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |->
      result_out.slot_set_rank <= 10'd923 && result_out.order_rank <= 10'd719)
    else $error("rank out of range");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_out.valid && !m_valid && !c_valid && !r_valid)
    else $error("valid stage after reset");

  // a transaction entering the first stage shows up there in the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> m_valid)
    else $error("accepted transaction lost at stage 1");
`endif

endmodule
